// ===== rtl/dramp_pkg.sv =====
// ----------------------------------------------------------------------------
// dramp_pkg
// shared widths, constants and sequencer codes of the duty ramp generator
// ----------------------------------------------------------------------------
package dramp_pkg;

   localparam int DutyW    = 16;
   localparam int RampDiv  = 20;
   localparam int WideW    = DutyW + 1;

   // x / 20 as (x * 52429) >> 20, exact for any 16-bit x
   localparam int RampRecip = 52429;
   localparam int RampShift = 20;

   localparam int StateW   = 3;

   typedef logic [DutyW-1:0]  duty_type;
   typedef logic [WideW-1:0]  wide_type;
   typedef logic [StateW-1:0] state_type;

   localparam state_type StIdle  = 3'd0;
   localparam state_type StMag   = 3'd1;
   localparam state_type StDiv   = 3'd2;
   localparam state_type StStep  = 3'd3;
   localparam state_type StFinal = 3'd4;

endpackage

// ===== rtl/duty_ramp_generator_top.sv =====
// ----------------------------------------------------------------------------
// duty_ramp_generator_top
// pwm duty slew ramp: walks from the current duty to each new target
// ----------------------------------------------------------------------------
// sequence: a target is taken in idle, then its magnitude and direction are
//   found; a small change (under 20) goes straight to the last word, while a
//   ramp first divides by 20 as one reciprocal multiply, then gives one word
//   per cycle while the receiver takes them, then the last word at the target
// ready only when idle, so a new target waits until the last word is issued
// reset: synchronous, clears the current duty to zero and drops the output valid
module duty_ramp_generator_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [dramp_pkg::DutyW-1:0] req_tdata,   // [15:0] target_duty
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [dramp_pkg::DutyW-1:0] rsp_tdata,   // [15:0] duty_value
   output logic                       rsp_tlast
);
   import dramp_pkg::*;

   state_type           state_ff, state_in;
   duty_type            cur_duty_ff, cur_duty_in;
   duty_type            target_ff, target_in;
   duty_type            mag_ff, mag_in;
   duty_type            step_ff, step_in;
   logic                up_ff, up_in;
   wide_type            cur_ff, cur_in;
   wide_type            walked_ff, walked_in;
   logic                rsp_tvalid_ff, rsp_tvalid_in;
   duty_type            rsp_tdata_ff, rsp_tdata_in;
   logic                rsp_tlast_ff, rsp_tlast_in;

   logic                slot_free;
   logic [2*DutyW-1:0]  recip_prod;
   wide_type            up_sum;
   wide_type            dn_diff;
   wide_type            next_cur;

   assign slot_free = !rsp_tvalid_ff || rsp_tready;

   // divide by 20 through the reciprocal
   assign recip_prod = mag_ff * DutyW'(RampRecip);

   assign up_sum  = cur_ff + {1'b0, step_ff};
   assign dn_diff = cur_ff - {1'b0, step_ff};

   always_comb begin
      if (up_ff) begin
         next_cur = (up_sum > {1'b0, target_ff}) ? {1'b0, target_ff} : up_sum;
      end else begin
         if (dn_diff[DutyW] || (dn_diff[DutyW-1:0] < target_ff)) begin
            next_cur = {1'b0, target_ff};
         end else begin
            next_cur = dn_diff;
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      cur_duty_in   = cur_duty_ff;
      target_in     = target_ff;
      mag_in        = mag_ff;
      step_in       = step_ff;
      up_in         = up_ff;
      cur_in        = cur_ff;
      walked_in     = walked_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tlast_in  = rsp_tlast_ff;

      case (state_ff)
         StIdle: begin
            if (req_tvalid) begin
               target_in = req_tdata;
               state_in  = StMag;
            end
         end
         StMag: begin
            up_in   = target_ff > cur_duty_ff;
            mag_in  = (target_ff > cur_duty_ff) ? target_ff - cur_duty_ff
                                                : cur_duty_ff - target_ff;
            cur_in  = {1'b0, cur_duty_ff};
            step_in = '0;
            if (mag_in < DutyW'(RampDiv)) begin
               state_in = StFinal;
            end else begin
               state_in = StDiv;
            end
         end
         StDiv: begin
            step_in   = DutyW'(recip_prod >> RampShift);
            walked_in = '0;
            state_in  = StStep;
         end
         StStep: begin
            if (slot_free) begin
               if (walked_ff < {1'b0, mag_ff}) begin
                  cur_in        = next_cur;
                  walked_in     = walked_ff + {1'b0, step_ff};
                  rsp_tvalid_in = 1'b1;
                  rsp_tdata_in  = next_cur[DutyW-1:0];
                  rsp_tlast_in  = 1'b0;
               end else begin
                  state_in = StFinal;
               end
            end
         end
         StFinal: begin
            if (slot_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = target_ff;
               rsp_tlast_in  = 1'b1;
               cur_duty_in   = target_ff;
               state_in      = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= StIdle;
         cur_duty_ff   <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cur_duty_ff   <= cur_duty_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      target_ff    <= target_in;
      mag_ff       <= mag_in;
      step_ff      <= step_in;
      up_ff        <= up_in;
      cur_ff       <= cur_in;
      walked_ff    <= walked_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tlast_ff <= rsp_tlast_in;
   end

   assign req_tready = (state_ff == StIdle);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   a_last_is_duty: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && rsp_tlast_ff) |-> (rsp_tdata_ff == cur_duty_ff))
      else $error("last word differs from current duty");

   a_step_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == StStep) |-> (step_ff != '0))
      else $error("ramp step is zero");

   a_accept_seq: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == StMag))
      else $error("accepted word did not start the sequencer");

endmodule
